// ===== rtl/pts_pkg.sv =====
// Shared types, codes and character classes of the token scanner.
`default_nettype none
package pts_pkg;

  localparam int MAX_RES  = 4;  // results one source word can cause
  localparam int QDEPTH   = 4;  // result-group queue entries
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // result kinds
  localparam logic [1:0] KIND_WORD  = 2'd0;
  localparam logic [1:0] KIND_PUNCT = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OPEN_COM = 2'd1;
  localparam logic [1:0] ERR_OPEN_STR = 2'd2;
  localparam logic [1:0] ERR_BAD_CHAR = 2'd3;

  // characters with a role of their own
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] kind;
    logic       tok_first;
    logic       tok_last;
    logic [1:0] err;
  } res_t;

  // all results of one source word; the line number travels beside it
  typedef struct packed {
    logic [1:0]               last_idx;
    res_t [MAX_RES-1:0]       res;
  } grp_t;

  function automatic res_t mk_res(logic [7:0] ch, logic [1:0] kind, logic first,
                                  logic last, logic [1:0] err);
    res_t r;
    r.ch        = ch;
    r.kind      = kind;
    r.tok_first = first;
    r.tok_last  = last;
    r.err       = err;
    return r;
  endfunction

  function automatic logic is_word(logic [7:0] c);
    logic r;
    case (c) inside
      [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
      8'h5F, 8'h24, 8'h25, 8'h2E: r = 1'b1;
      default:                    r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    logic r;
    case (c) inside
      8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: r = 1'b1;
      default:                                  r = 1'b0;
    endcase
    return r;
  endfunction

  // , ; : ( ) [ ] { } @ + < > ! - = * |
  function automatic logic is_punct(logic [7:0] c);
    logic r;
    case (c) inside
      8'h2C, 8'h3B, 8'h3A, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D,
      8'h40, 8'h2B, 8'h3C, 8'h3E, 8'h21, 8'h2D, 8'h3D, 8'h2A, 8'h7C: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pts_front.sv =====
// Front end: scanner FSM, one source word per accept cycle, builds result groups.
`default_nettype none
module pts_front #(
  parameter int LINE_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 mode,
  input  logic [7:0]           char_in,
  output logic                 grp_vld,
  output pts_pkg::grp_t        grp,
  output logic [LINE_BITS-1:0] grp_line
);
  import pts_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_WORD  = 7'b0000010,
    ST_SLASH = 7'b0000100,
    ST_LCOM  = 7'b0001000,
    ST_BCOM  = 7'b0010000,
    ST_BSTAR = 7'b0100000,
    ST_STR   = 7'b1000000
  } scan_st_t;

  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [LINE_BITS-1:0] LINE_TOP = '1;

  scan_st_t             st_r, st_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [LINE_BITS-1:0] cline_r, cline_nxt;
  logic [7:0]           held_r, held_nxt;    // held colons are always ':'
  logic [1:0]           hcnt_r, hcnt_nxt;
  logic                 topen_r, topen_nxt;
  logic                 err_r, err_nxt;

  logic [2:0]           n;
  res_t [MAX_RES-1:0]   rv;
  logic [LINE_BITS-1:0] gline;
  logic [LINE_BITS-1:0] li;
  logic                 flush_go;
  logic                 idle_go;

  always_comb begin
    st_nxt    = st_r;
    line_nxt  = line_r;
    cline_nxt = cline_r;
    held_nxt  = held_r;
    hcnt_nxt  = hcnt_r;
    topen_nxt = topen_r;
    err_nxt   = err_r;
    n         = '0;
    rv        = '0;
    gline     = line_r;
    flush_go  = 1'b0;
    idle_go   = 1'b0;
    li        = (line_r == LINE_TOP) ? line_r : line_r + LINE_BITS'(1);

    // first step: decisions that come before a possible word flush
    if (!err_r) begin
      if (mode) begin
        case (st_r)
          ST_WORD:  flush_go = 1'b1;
          ST_SLASH: begin
            rv[n[1:0]] = mk_res(8'h00, KIND_ERR, 1'b0, 1'b0, ERR_BAD_CHAR);
            n = n + 3'd1;
            err_nxt = 1'b1;
          end
          ST_BCOM, ST_BSTAR: begin
            rv[n[1:0]] = mk_res(8'h00, KIND_ERR, 1'b0, 1'b0, ERR_OPEN_COM);
            n = n + 3'd1;
            gline = cline_r;
            err_nxt = 1'b1;
          end
          ST_STR: begin
            rv[n[1:0]] = mk_res(8'h00, KIND_ERR, 1'b0, 1'b0, ERR_OPEN_STR);
            n = n + 3'd1;
            err_nxt = 1'b1;
          end
          default: ;
        endcase
      end else begin
        case (st_r)
          ST_WORD: begin
            if (hcnt_r <= 2'd1) begin
              if (is_word(char_in)) begin
                rv[n[1:0]] = mk_res(held_r, KIND_WORD, !topen_r, 1'b0, ERR_NONE);
                n = n + 3'd1;
                topen_nxt = 1'b1;
                held_nxt  = char_in;
                hcnt_nxt  = 2'd1;
              end else if (char_in == CH_COLON) begin
                hcnt_nxt = 2'd2;
              end else begin
                flush_go = 1'b1;
                idle_go  = 1'b1;
              end
            end else if (hcnt_r == 2'd2) begin
              if (char_in == CH_COLON) begin
                hcnt_nxt = 2'd3;
              end else begin
                flush_go = 1'b1;
                idle_go  = 1'b1;
              end
            end else if (is_word(char_in)) begin
              // doubled colon followed by a word char stays in the word
              rv[n[1:0]] = mk_res(held_r, KIND_WORD, !topen_r, 1'b0, ERR_NONE);
              n = n + 3'd1;
              rv[n[1:0]] = mk_res(CH_COLON, KIND_WORD, 1'b0, 1'b0, ERR_NONE);
              n = n + 3'd1;
              rv[n[1:0]] = mk_res(CH_COLON, KIND_WORD, 1'b0, 1'b0, ERR_NONE);
              n = n + 3'd1;
              topen_nxt = 1'b1;
              held_nxt  = char_in;
              hcnt_nxt  = 2'd1;
            end else begin
              flush_go = 1'b1;
              idle_go  = 1'b1;
            end
          end
          ST_SLASH: begin
            hcnt_nxt = 2'd0;
            if (char_in == CH_SLASH) begin
              st_nxt = ST_LCOM;
            end else if (char_in == CH_STAR) begin
              cline_nxt = line_r;
              st_nxt    = ST_BCOM;
            end else begin
              rv[n[1:0]] = mk_res(8'h00, KIND_ERR, 1'b0, 1'b0, ERR_BAD_CHAR);
              n = n + 3'd1;
              err_nxt = 1'b1;
              st_nxt  = ST_IDLE;
            end
          end
          ST_LCOM: begin
            if (char_in == CH_NL) begin
              line_nxt = li;
              st_nxt   = ST_IDLE;
            end
          end
          ST_BCOM, ST_BSTAR: begin
            if (st_r == ST_BSTAR && char_in == CH_SLASH) begin
              st_nxt = ST_IDLE;
            end else if (char_in == CH_STAR) begin
              st_nxt = ST_BSTAR;
            end else begin
              if (char_in == CH_NL) line_nxt = li;
              st_nxt = ST_BCOM;
            end
          end
          ST_STR: begin
            // string token takes the line as counted after this char
            if (char_in == CH_NL) begin
              line_nxt = li;
              gline    = li;
            end
            rv[n[1:0]] = mk_res(char_in, KIND_WORD, 1'b0, char_in == CH_QUOTE, ERR_NONE);
            n = n + 3'd1;
            if (char_in == CH_QUOTE) st_nxt = ST_IDLE;
          end
          default: idle_go = 1'b1;
        endcase
      end
    end

    // close the held word: last word char, then any held colons as punct
    if (flush_go) begin
      rv[n[1:0]] = mk_res(held_r, KIND_WORD, !topen_r, 1'b1, ERR_NONE);
      n = n + 3'd1;
      if (hcnt_r >= 2'd2) begin
        rv[n[1:0]] = mk_res(CH_COLON, KIND_PUNCT, 1'b1, 1'b1, ERR_NONE);
        n = n + 3'd1;
      end
      if (hcnt_r == 2'd3) begin
        rv[n[1:0]] = mk_res(CH_COLON, KIND_PUNCT, 1'b1, 1'b1, ERR_NONE);
        n = n + 3'd1;
      end
      hcnt_nxt  = 2'd0;
      topen_nxt = 1'b0;
      st_nxt    = ST_IDLE;
    end

    // char between tokens
    if (idle_go) begin
      if (char_in == CH_NL) begin
        line_nxt = li;
      end else if (is_space(char_in)) begin
        line_nxt = line_r;
      end else if (char_in == CH_SLASH) begin
        held_nxt = char_in;
        hcnt_nxt = 2'd1;
        st_nxt   = ST_SLASH;
      end else if (char_in == CH_QUOTE) begin
        rv[n[1:0]] = mk_res(char_in, KIND_WORD, 1'b1, 1'b0, ERR_NONE);
        n = n + 3'd1;
        st_nxt = ST_STR;
      end else if (is_word(char_in)) begin
        held_nxt  = char_in;
        hcnt_nxt  = 2'd1;
        topen_nxt = 1'b0;
        st_nxt    = ST_WORD;
      end else if (is_punct(char_in)) begin
        rv[n[1:0]] = mk_res(char_in, KIND_PUNCT, 1'b1, 1'b1, ERR_NONE);
        n = n + 3'd1;
      end else begin
        rv[n[1:0]] = mk_res(8'h00, KIND_ERR, 1'b0, 1'b0, ERR_BAD_CHAR);
        n = n + 3'd1;
        err_nxt  = 1'b1;
        st_nxt   = ST_IDLE;
        hcnt_nxt = 2'd0;
      end
    end

    // end of source: End token unless an error was raised, then restart
    if (mode) begin
      if (!err_r && !err_nxt) begin
        rv[n[1:0]] = mk_res(8'h00, KIND_END, 1'b1, 1'b1, ERR_NONE);
        n = n + 3'd1;
      end
      st_nxt    = ST_IDLE;
      line_nxt  = LINE_ONE;
      cline_nxt = LINE_ONE;
      hcnt_nxt  = 2'd0;
      topen_nxt = 1'b0;
      err_nxt   = 1'b0;
    end
  end

  assign grp_vld      = accept && (n != 3'd0);
  assign grp.last_idx = 2'(n - 3'd1);
  assign grp.res      = rv;
  assign grp_line     = gline;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      line_r  <= LINE_ONE;
      cline_r <= LINE_ONE;
      hcnt_r  <= 2'd0;
      topen_r <= 1'b0;
      err_r   <= 1'b0;
    end else if (accept) begin
      st_r    <= st_nxt;
      line_r  <= line_nxt;
      cline_r <= cline_nxt;
      hcnt_r  <= hcnt_nxt;
      topen_r <= topen_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) held_r <= held_nxt;
  end

`ifndef SYNTHESIS
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (st_r == ST_IDLE) && (hcnt_r == 2'd0))
    else $error("error latched with scanner not idle");
  a_word_held: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WORD) |-> (hcnt_r != 2'd0))
    else $error("word state without held char");
  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode) |=> (line_r == LINE_ONE) && !err_r && (st_r == ST_IDLE))
    else $error("scanner did not restart after end of source");
`endif

endmodule
`default_nettype wire

// ===== rtl/pts_queue.sv =====
// Short queue of result groups between scanner front and output back end.
`default_nettype none
module pts_queue #(
  parameter int LINE_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pts_pkg::grp_t        grp_in,
  input  logic [LINE_BITS-1:0] line_in,
  input  logic                 pop,
  output logic                 full,
  output logic                 vld,
  output pts_pkg::grp_t        grp_out,
  output logic [LINE_BITS-1:0] line_out
);
  import pts_pkg::*;

  grp_t                 grp_mem [QDEPTH];
  logic [LINE_BITS-1:0] line_mem [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign vld      = (cnt_r != '0);
  assign grp_out  = grp_mem[rd_ptr_r];
  assign line_out = line_mem[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      grp_mem[wr_ptr_r]  <= grp_in;
      line_mem[wr_ptr_r] <= line_in;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (full |-> !push) and (!vld |-> !pop))
    else $error("group queue pushed when full or popped when empty");
`endif

endmodule
`default_nettype wire

// ===== rtl/pts_back.sv =====
// Back end: walks each queued group and drives the registered result channel.
`default_nettype none
module pts_back #(
  parameter int LINE_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_vld,
  input  pts_pkg::grp_t        q_grp,
  input  logic [LINE_BITS-1:0] q_line,
  output logic                 q_pop,
  output logic                 out_vld,
  input  logic                 out_rdy,
  output pts_pkg::res_t        out_res,
  output logic [LINE_BITS-1:0] out_line,
  output logic                 out_last
);
  import pts_pkg::*;

  logic                 out_vld_r, out_vld_nxt;
  res_t                 res_r;
  logic [LINE_BITS-1:0] line_r;
  logic                 last_r;
  logic [1:0]           idx_r, idx_nxt;
  logic                 load;

  assign load  = q_vld && (!out_vld_r || out_rdy);
  assign q_pop = load && (idx_r == q_grp.last_idx);

  always_comb begin
    idx_nxt     = idx_r;
    if (load) idx_nxt = q_pop ? 2'd0 : idx_r + 2'd1;
    out_vld_nxt = load || (out_vld_r && !out_rdy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      idx_r     <= 2'd0;
    end else begin
      out_vld_r <= out_vld_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= q_grp.res[idx_r];
      line_r <= q_line;
      last_r <= q_pop;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_res  = res_r;
  assign out_line = line_r;
  assign out_last = last_r;

`ifndef SYNTHESIS
  a_idx_in_grp: assert property (@(posedge clk) disable iff (!rst_n)
    q_vld |-> (idx_r <= q_grp.last_idx))
    else $error("result index beyond queued group");
`endif

endmodule
`default_nettype wire

// ===== rtl/ptx_token_scanner_unit.sv =====
// Top level of the token scanner: front scanner, group queue, output back end.
//
// Input channel (in_*): one word per source byte. in_tuser = 1 marks end of
//   source, and in_tdata is then ignored. A word is taken at an edge with
//   in_tvalid and in_tready both high.
// Result channel (out_*): one word per token character, End token or error,
//   with out_tlast on the final result word caused by one input word.
// Throughput: one input word per cycle while the queue has room. Each input word
//   is scanned in the cycle it is taken, and its results, up to four, go as one
//   group into a four-entry queue; a word without results adds no group. The
//   back end then sends one result word per cycle while out_tready is high.
// Path: the first result word of an input word is written into a queue entry,
//   then into the output register, and from there it is on out_*.
// Stall: while out_tready is low the output register holds its word; the
//   front keeps taking input until the queue holds four groups, then drops
//   in_tready.
// Reset: synchronous, active low. The scanner returns to the state between
//   tokens at line one with the error flag clear; the queue and output
//   register are emptied. After an error, input is discarded without result
//   until the end-of-source word, which restarts the scanner.
`default_nettype none
module ptx_token_scanner_unit #(
  parameter int LINE_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] char_in
  input  logic                           in_tuser,   // [0] mode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] out_char, [LINE_BITS+7:8] line_no, [LINE_BITS+9:LINE_BITS+8] error_code, zero pad
  output logic [((10+LINE_BITS+7)/8)*8-1:0] out_tdata,
  output logic [3:0]                     out_tuser,  // [1:0] kind, [2] token_start, [3] token_end
  output logic                           out_tlast
);
  import pts_pkg::*;

  localparam int OUT_TDATA_W = ((10 + LINE_BITS + 7) / 8) * 8;

  logic                 accept;
  logic                 f_vld;
  grp_t                 f_grp;
  logic [LINE_BITS-1:0] f_line;

  logic                 q_full;
  logic                 q_vld;
  logic                 q_pop;
  grp_t                 q_grp;
  logic [LINE_BITS-1:0] q_line;

  res_t                 b_res;
  logic [LINE_BITS-1:0] b_line;

  // input is taken whenever the group queue has room
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  pts_front #(.LINE_BITS(LINE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .mode     (in_tuser),
    .char_in  (in_tdata),
    .grp_vld  (f_vld),
    .grp      (f_grp),
    .grp_line (f_line)
  );

  pts_queue #(.LINE_BITS(LINE_BITS)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_vld),
    .grp_in   (f_grp),
    .line_in  (f_line),
    .pop      (q_pop),
    .full     (q_full),
    .vld      (q_vld),
    .grp_out  (q_grp),
    .line_out (q_line)
  );

  pts_back #(.LINE_BITS(LINE_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_vld    (q_vld),
    .q_grp    (q_grp),
    .q_line   (q_line),
    .q_pop    (q_pop),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_res  (b_res),
    .out_line (b_line),
    .out_last (out_tlast)
  );

  // pack result word, pad bits above the error code are zero
  assign out_tdata = OUT_TDATA_W'({b_res.err, b_line, b_res.ch});
  assign out_tuser = {b_res.tok_last, b_res.tok_first, b_res.kind};

endmodule
`default_nettype wire

// ===== verif/ptx_token_scanner_unit_test.sv =====
// Self-checking testbench of the token scanner: directed table, then random sources.
`default_nettype none
module ptx_token_scanner_unit_test;
  import pts_pkg::*;

  localparam int LINE_BITS   = 20;
  localparam int TDATA_W     = ((10 + LINE_BITS + 7) / 8) * 8;
  localparam int DIR_N       = 29;
  localparam int RAND_WORDS  = 150;   // random source words, noise included
  localparam int HOLD_CYCLES = 60;    // long receiver hold-off
  localparam int IDLE_LIMIT  = 2000;  // cycles with no handshake on either side
  localparam int PRINT_MAX   = 30;
  localparam logic [LINE_BITS-1:0] LINE_TOP = '1;

  // scanner states, kept here for the predictor only
  typedef enum logic [6:0] {
    SC_IDLE     = 7'b0000001,
    SC_WORD     = 7'b0000010,
    SC_SLASH    = 7'b0000100,
    SC_LINE_COM = 7'b0001000,
    SC_BLK_COM  = 7'b0010000,
    SC_BLK_STAR = 7'b0100000,
    SC_STRING   = 7'b1000000
  } scan_t;

  // one result word as the predictor sees it
  typedef struct packed {
    logic [7:0]           ch;
    logic [1:0]           kind;
    logic                 first;
    logic                 fin;
    logic [LINE_BITS-1:0] line;
    logic [1:0]           err;
    logic                 last;
  } tok_word_t;

  // one row of the directed table; exp is used only where typed is set
  typedef struct packed {
    logic      mode;
    logic [7:0] ch;
    logic      typed;
    tok_word_t exp;
  } stim_row_t;

  localparam string WORD_SET =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_$%.";
  localparam string PUNCT_SET = ",;:()[]{}@+<>!-=*|";

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata   = 8'h00;
  logic               in_tuser   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [3:0]         out_tuser;
  logic               out_tlast;

  // travels with each input word: a typed expectation replaces the prediction
  logic      row_typed = 1'b0;
  tok_word_t row_exp   = '0;

  ptx_token_scanner_unit #(.LINE_BITS(LINE_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // ---------------------------------------------------------------------------
  // Scanner predictor: own state, fills tok_due_q with the words it expects
  // ---------------------------------------------------------------------------
  tok_word_t      tok_due_q[$];
  scan_t          sc;
  logic [LINE_BITS-1:0] cur_line, blk_line;
  logic [7:0]     held [3];
  int unsigned    n_held;
  logic           tok_open, err_seen;
  int unsigned    step_n;

  function automatic logic sym_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           c == "_" || c == "$" || c == "%" || c == ".";
  endfunction

  function automatic logic blank_char(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic punct_char(logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < PUNCT_SET.len(); k++)
      if (PUNCT_SET[k] == c) hit = 1'b1;
    return hit;
  endfunction

  task automatic due_add(input tok_word_t w);
    tok_due_q = {tok_due_q, w};
  endtask

  task automatic lex_reset();
    sc       = SC_IDLE;
    cur_line = LINE_BITS'(1);
    blk_line = LINE_BITS'(1);
    n_held   = 0;
    tok_open = 1'b0;
    err_seen = 1'b0;
  endtask

  task automatic bump_line();
    if (cur_line != LINE_TOP) cur_line = cur_line + 1'b1;
  endtask

  // at most MAX_RES words per input word
  task automatic put(input logic [7:0] ch, input logic [1:0] kind, input logic first,
                     input logic fin, input logic [LINE_BITS-1:0] line,
                     input logic [1:0] err);
    tok_word_t r;
    if (step_n < MAX_RES) begin
      r.ch = ch; r.kind = kind; r.first = first; r.fin = fin;
      r.line = line; r.err = err; r.last = 1'b0;
      due_add(r);
      step_n++;
    end
  endtask

  task automatic lex_error(input logic [1:0] code, input logic [LINE_BITS-1:0] line);
    put(8'h00, KIND_ERR, 1'b0, 1'b0, line, code);
    err_seen = 1'b1;
    sc       = SC_IDLE;
    n_held   = 0;
  endtask

  task automatic lex_idle(input logic [7:0] c);
    if (c == CH_NL) begin
      bump_line();
    end else if (blank_char(c)) begin
      // dropped
    end else if (c == CH_SLASH) begin
      held[0] = c; n_held = 1; sc = SC_SLASH;
    end else if (c == CH_QUOTE) begin
      put(c, KIND_WORD, 1'b1, 1'b0, cur_line, ERR_NONE);
      sc = SC_STRING;
    end else if (sym_char(c)) begin
      held[0] = c; n_held = 1; tok_open = 1'b0; sc = SC_WORD;
    end else if (punct_char(c)) begin
      put(c, KIND_PUNCT, 1'b1, 1'b1, cur_line, ERR_NONE);
    end else begin
      lex_error(ERR_BAD_CHAR, cur_line);
    end
  endtask

  // close the word; held colons leave as single punctuation tokens
  task automatic lex_flush();
    put(held[0], KIND_WORD, !tok_open, 1'b1, cur_line, ERR_NONE);
    for (int k = 1; k < n_held; k++)
      put(held[k], KIND_PUNCT, 1'b1, 1'b1, cur_line, ERR_NONE);
    n_held   = 0;
    tok_open = 1'b0;
    sc       = SC_IDLE;
  endtask

  // one char is held back, or up to three while a doubled colon is undecided
  task automatic lex_word(input logic [7:0] c);
    if (n_held <= 1) begin
      if (sym_char(c)) begin
        put(held[0], KIND_WORD, !tok_open, 1'b0, cur_line, ERR_NONE);
        tok_open = 1'b1; held[0] = c; n_held = 1;
        return;
      end
      if (c == CH_COLON) begin
        held[1] = c; n_held = 2;
        return;
      end
    end else if (n_held == 2) begin
      if (c == CH_COLON) begin
        held[2] = c; n_held = 3;
        return;
      end
    end else if (sym_char(c)) begin
      put(held[0], KIND_WORD, !tok_open, 1'b0, cur_line, ERR_NONE);
      put(held[1], KIND_WORD, 1'b0, 1'b0, cur_line, ERR_NONE);
      put(held[2], KIND_WORD, 1'b0, 1'b0, cur_line, ERR_NONE);
      tok_open = 1'b1; held[0] = c; n_held = 1;
      return;
    end
    lex_flush();
    lex_idle(c);
  endtask

  task automatic lex_step(input logic mode, input logic [7:0] c);
    int unsigned base;
    tok_word_t   tail;
    base   = tok_due_q.size();
    step_n = 0;
    if (mode) begin
      if (!err_seen) begin
        case (sc)
          SC_WORD:                 lex_flush();
          SC_SLASH:                lex_error(ERR_BAD_CHAR, cur_line);
          SC_BLK_COM, SC_BLK_STAR: lex_error(ERR_OPEN_COM, blk_line);
          SC_STRING:               lex_error(ERR_OPEN_STR, cur_line);
          default: ;
        endcase
        if (!err_seen) put(8'h00, KIND_END, 1'b1, 1'b1, cur_line, ERR_NONE);
      end
      lex_reset();
    end else if (!err_seen) begin
      case (sc)
        SC_WORD: lex_word(c);
        SC_SLASH: begin
          n_held = 0;
          if (c == CH_SLASH) begin
            sc = SC_LINE_COM;
          end else if (c == CH_STAR) begin
            blk_line = cur_line;
            sc = SC_BLK_COM;
          end else begin
            lex_error(ERR_BAD_CHAR, cur_line);
          end
        end
        SC_LINE_COM: begin
          if (c == CH_NL) begin
            bump_line();
            sc = SC_IDLE;
          end
        end
        SC_BLK_COM, SC_BLK_STAR: begin
          if (sc == SC_BLK_STAR && c == CH_SLASH) begin
            sc = SC_IDLE;
          end else if (c == CH_STAR) begin
            sc = SC_BLK_STAR;
          end else begin
            if (c == CH_NL) bump_line();
            sc = SC_BLK_COM;
          end
        end
        SC_STRING: begin
          if (c == CH_NL) bump_line();
          put(c, KIND_WORD, 1'b0, c == CH_QUOTE, cur_line, ERR_NONE);
          if (c == CH_QUOTE) sc = SC_IDLE;
        end
        default: lex_idle(c);
      endcase
    end
    if (tok_due_q.size() > base) begin
      tail = tok_due_q[tok_due_q.size() - 1];
      tail.last = 1'b1;
      tok_due_q[tok_due_q.size() - 1] = tail;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Bus monitor: checks result words, feeds accepted input words to the predictor
  // ---------------------------------------------------------------------------
  int unsigned mismatches = 0;
  int unsigned n_in = 0, n_src = 0, n_out = 0, n_err_res = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_MAX)
      $display("[%0t] result word %0d, %s: got 0x%0h, want 0x%0h",
               $realtime, n_out, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    tok_word_t e;
    if (tok_due_q.size() == 0) begin
      report_mismatch("word with nothing pending", out_tdata, 0);
      return;
    end
    e = tok_due_q.pop_front();
    if (out_tdata[7:0] != e.ch)
      report_mismatch("char", out_tdata[7:0], e.ch);
    if (out_tuser[1:0] != e.kind)
      report_mismatch("kind", out_tuser[1:0], e.kind);
    if (out_tuser[2] != e.first)
      report_mismatch("token start", out_tuser[2], e.first);
    if (out_tuser[3] != e.fin)
      report_mismatch("token end", out_tuser[3], e.fin);
    if (out_tdata[LINE_BITS+7:8] != e.line)
      report_mismatch("line", out_tdata[LINE_BITS+7:8], e.line);
    if (out_tdata[LINE_BITS+9:LINE_BITS+8] != e.err)
      report_mismatch("error code", out_tdata[LINE_BITS+9:LINE_BITS+8], e.err);
    if (out_tdata[TDATA_W-1:LINE_BITS+10] != '0)
      report_mismatch("padding", out_tdata[TDATA_W-1:LINE_BITS+10], 0);
    if (out_tlast != e.last)
      report_mismatch("tlast", out_tlast, e.last);
  endtask

  always @(posedge clk) begin : bus_watch
    int unsigned base;
    if (out_tvalid && out_tready) begin
      check_result();
      n_out++;
      if (out_tuser[1:0] == KIND_ERR) n_err_res++;
    end
    if (in_tvalid && in_tready) begin
      base = tok_due_q.size();
      lex_step(in_tuser, in_tdata);
      if (row_typed) begin
        // directed rows with an obvious answer: the table's word stands
        while (tok_due_q.size() > base) void'(tok_due_q.pop_back());
        due_add(row_exp);
      end
      n_in++;
      if (in_tuser) n_src++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern of its own, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0, hold_left = 0, rx_tick = 0, rx_style = 0;
  logic [7:0]  rx_mask = 8'hFF;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      if (rx_tick % 48 == 0) begin
        rx_style = $urandom_range(0, 3);
        rx_mask  = 8'($urandom);
      end
      rx_tick++;
      case (rx_style)
        0:       out_tready <= 1'b1;                      // no stalls at all
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        2:       out_tready <= rx_mask[rx_tick % 8];     // rotating mask
        default: out_tready <= ($urandom_range(0, 9) < 4); // heavy stalling
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run when neither side moves for too long
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  bit          no_gaps = 1'b0;
  int unsigned n_sent = 0;

  task automatic send_word(input logic mode, input logic [7:0] c,
                           input logic typed = 1'b0, input tok_word_t e = '0);
    int unsigned gap;
    if (!no_gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= c;
    row_typed <= typed;
    row_exp   <= e;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) burst_left--;
    n_sent++;
  endtask

  // stop offering and wait until every pending result word is back
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tok_due_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random source text
  // ---------------------------------------------------------------------------
  logic [7:0] src_q[$];

  task automatic src_add(input logic [7:0] b);
    src_q = {src_q, b};
  endtask

  function automatic logic [7:0] word_byte();
    return WORD_SET[$urandom_range(0, WORD_SET.len() - 1)];
  endfunction

  function automatic logic [7:0] punct_byte();
    return PUNCT_SET[$urandom_range(0, PUNCT_SET.len() - 1)];
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return CH_NL;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  // printable text; block comments get stars and newlines but never a slash
  function automatic logic [7:0] text_byte(input bit in_block);
    logic [7:0] b;
    b = 8'($urandom_range(8'h20, 8'h7E));
    if (in_block) begin
      if (b == CH_SLASH) b = CH_STAR;
      if ($urandom_range(0, 5) == 0) b = CH_NL;
    end
    return b;
  endfunction

  // mostly well-formed pieces with random content, about one in twelve is noise
  task automatic gen_source();
    logic [7:0] b;
    src_q.delete();
    repeat ($urandom_range(2, 9)) begin
      case ($urandom_range(0, 11))
        0, 1: src_add(blank_byte());
        2, 3, 4: begin
          repeat ($urandom_range(1, 5)) src_add(word_byte());
          case ($urandom_range(0, 5))
            0: begin       // doubled colon inside the word
              src_add(CH_COLON); src_add(CH_COLON);
              repeat ($urandom_range(1, 3)) src_add(word_byte());
            end
            1: src_add(CH_COLON);
            2: begin src_add(CH_COLON); src_add(CH_COLON); end
            default: ;
          endcase
        end
        5: src_add(punct_byte());
        6: begin
          src_add(CH_QUOTE);
          repeat ($urandom_range(0, 5)) begin
            b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : text_byte(1'b0);
            src_add(b == CH_QUOTE ? CH_NL : b);
          end
          src_add(CH_QUOTE);
        end
        7: begin
          src_add(CH_SLASH); src_add(CH_SLASH);
          repeat ($urandom_range(0, 6)) src_add(text_byte(1'b0));
          src_add(CH_NL);
        end
        8: begin
          src_add(CH_SLASH); src_add(CH_STAR);
          repeat ($urandom_range(0, 6)) src_add(text_byte(1'b1));
          src_add(CH_STAR); src_add(CH_SLASH);
        end
        9: src_add(CH_NL);
        10: begin src_add(blank_byte()); src_add(punct_byte()); end
        default: begin
          case ($urandom_range(0, 3))
            0: src_add(8'($urandom_range(0, 255)));
            1: src_add(CH_SLASH);                      // lone slash
            2: begin src_add(CH_SLASH); src_add(CH_STAR); end
            default: src_add(CH_QUOTE);                // may stay open
          endcase
        end
      endcase
    end
    foreach (src_q[i]) send_word(1'b0, src_q[i]);
    send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------
  function automatic tok_word_t at_line1(logic [7:0] ch, logic [1:0] kind, logic first,
                                         logic fin, logic [1:0] err);
    tok_word_t r;
    r.ch = ch; r.kind = kind; r.first = first; r.fin = fin;
    r.line = LINE_BITS'(1); r.err = err; r.last = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t plain(logic mode, logic [7:0] c);
    stim_row_t r;
    r.mode = mode; r.ch = c; r.typed = 1'b0; r.exp = '0;
    return r;
  endfunction

  function automatic stim_row_t typed(logic mode, logic [7:0] c, tok_word_t e);
    stim_row_t r;
    r.mode = mode; r.ch = c; r.typed = 1'b1; r.exp = e;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  stim_row_t dir_tab [DIR_N];

  initial begin : main_seq
    int unsigned rand_base;
    bit          held_off;
    lex_reset();
    held_off = 1'b0;

    dir_tab = '{
      // end marker straight after reset, char ignored
      typed(1'b1, 8'hFF, at_line1(8'h00, KIND_END, 1'b1, 1'b1, ERR_NONE)),
      typed(1'b0, ",",   at_line1(",", KIND_PUNCT, 1'b1, 1'b1, ERR_NONE)),
      // a.:b -> single colon after a word ends it
      plain(1'b0, "a"), plain(1'b0, "."), plain(1'b0, ":"), plain(1'b0, "b"),
      // b::c -> doubled colon kept inside the word
      plain(1'b0, ":"), plain(1'b0, ":"), plain(1'b0, "c"),
      // c::) -> doubled colon with no word char after: four words at once
      plain(1'b0, ":"), plain(1'b0, ":"), plain(1'b0, ")"),
      // string across a newline
      plain(1'b0, CH_QUOTE), plain(1'b0, CH_NL), plain(1'b0, CH_QUOTE),
      // line comment
      plain(1'b0, CH_SLASH), plain(1'b0, CH_SLASH), plain(1'b0, CH_NL),
      // block comment left open at the end marker
      plain(1'b0, CH_SLASH), plain(1'b0, CH_STAR), plain(1'b0, CH_NL), plain(1'b1, 8'h00),
      // non-ASCII byte, then discard until the end marker
      typed(1'b0, 8'h80, at_line1(8'h00, KIND_ERR, 1'b0, 1'b0, ERR_BAD_CHAR)),
      plain(1'b0, "z"), plain(1'b1, "z"),
      // lone slash at the end marker
      plain(1'b0, CH_SLASH),
      typed(1'b1, 8'h00, at_line1(8'h00, KIND_ERR, 1'b0, 1'b0, ERR_BAD_CHAR)),
      // string left open at the end marker
      plain(1'b0, CH_QUOTE),
      typed(1'b1, 8'h00, at_line1(8'h00, KIND_ERR, 1'b0, 1'b0, ERR_OPEN_STR))
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_word(dir_tab[i].mode, dir_tab[i].ch, dir_tab[i].typed,
                                   dir_tab[i].exp);

    // random sources; one of them meets a long receiver hold-off
    rand_base = n_sent;
    while (n_sent - rand_base < RAND_WORDS) begin
      gen_source();
      if (!held_off && n_sent - rand_base > 80) begin
        held_off = 1'b1;
        @(posedge clk);
        hold_req++;
        // back-to-back single-result words fill the group queue
        no_gaps = 1'b1;
        repeat (16) send_word(1'b0, punct_byte());
        no_gaps = 1'b0;
        send_word(1'b1, 8'h00);
        drain();
      end
    end

    drain();
    repeat (12) @(posedge clk);

    $display("Run: %0d input words over %0d sources, %0d result words (%0d errors),",
             n_in, n_src, n_out, n_err_res);
    $display("  with a held-off receiver stalling the input and full drains between phases.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== ptx_token_scanner_unit.f =====
rtl/pts_pkg.sv
rtl/pts_front.sv
rtl/pts_queue.sv
rtl/pts_back.sv
rtl/ptx_token_scanner_unit.sv
verif/ptx_token_scanner_unit_test.sv
